/* sv/nacalu_pkg.sv */
`timescale 1ns / 1ps
package nacalu_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned DivStages = DataW;          // one quotient bit per stage
  localparam int unsigned PostStage = DivStages + 1;  // sign fix-up stage
  localparam int unsigned FifoDepth = 4;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MOD = 4'd4,
    OP_EQ  = 4'd5,
    OP_NE  = 4'd6,
    OP_GT  = 4'd7,
    OP_LT  = 4'd8,
    OP_GE  = 4'd9,
    OP_LE  = 4'd10,
    OP_AND = 4'd11,
    OP_OR  = 4'd12
  } op_e;

  typedef enum logic [2:0] {
    KIND_BOOL = 3'd0,
    KIND_I8   = 3'd1,
    KIND_I16  = 3'd2,
    KIND_I32  = 3'd3,
    KIND_I64  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    BC_NONE  = 2'd0,
    BC_RIGHT = 2'd1,
    BC_LEFT  = 2'd2
  } bcast_e;

  typedef enum logic [2:0] {
    REG_OP     = 3'd0,
    REG_LKIND  = 3'd1,
    REG_RKIND  = 3'd2,
    REG_BCAST  = 3'd3,
    REG_SCALAR = 3'd4
  } reg_e;

  // one classified row as it travels from front to back
  typedef struct packed {
    logic               bad;
    op_e                op;
    kind_e              resk;
    logic               pre_null;
    logic               an;
    logic               bn;
    logic               last;
    logic [DataW-1:0]   x;
    logic [DataW-1:0]   y;
    logic [DataW-1:0]   ax;
    logic [DataW-1:0]   ay;
    logic [DataW-1:0]   res;
  } item_t;

  // keep the low bits of a kind and sign-extend; bool reads as 8 bits
  function automatic logic [DataW-1:0] sext_kind(logic [DataW-1:0] v, kind_e k);
    logic [DataW-1:0] r;
    case (k)
      KIND_I16: r = {{48{v[15]}}, v[15:0]};
      KIND_I32: r = {{32{v[31]}}, v[31:0]};
      KIND_I64: r = v;
      default:  r = {{56{v[7]}}, v[7:0]};
    endcase
    return r;
  endfunction

  function automatic logic [DataW-1:0] kind_min(kind_e k);
    logic [DataW-1:0] r;
    case (k)
      KIND_I16: r = {{49{1'b1}}, 15'd0};
      KIND_I32: r = {{33{1'b1}}, 31'd0};
      KIND_I64: r = {1'b1, 63'd0};
      default:  r = {{57{1'b1}}, 7'd0};
    endcase
    return r;
  endfunction

endpackage

/* sv/nacalu_front.sv */
`timescale 1ns / 1ps
module nacalu_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [63:0]           cfg_data_i,
  input  logic [63:0]           operand_a_i,
  input  logic [63:0]           operand_b_i,
  input  logic                  last_row_i,
  output nacalu_pkg::item_t     item_o
);
  import nacalu_pkg::*;

  logic [3:0]  op_q;
  logic [2:0]  lk_q, rk_q;
  logic [1:0]  bm_q;
  logic [63:0] scalar_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= OP_ADD;
      lk_q     <= KIND_I8;
      rk_q     <= KIND_I8;
      bm_q     <= BC_NONE;
      scalar_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OP:     op_q     <= cfg_data_i[3:0];
        REG_LKIND:  lk_q     <= cfg_data_i[2:0];
        REG_RKIND:  rk_q     <= cfg_data_i[2:0];
        REG_BCAST:  bm_q     <= cfg_data_i[1:0];
        REG_SCALAR: scalar_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [63:0] a, b, xa, yb;
  logic        bad, is_divmod, is_logic, is_cmp, an, bn;
  kind_e       lk, rk, lk8, rk8;

  always_comb begin
    a  = (bm_q == BC_LEFT)  ? scalar_q : operand_a_i;
    b  = (bm_q == BC_RIGHT) ? scalar_q : operand_b_i;
    lk = kind_e'(lk_q);
    rk = kind_e'(rk_q);
    is_divmod = (op_q == OP_DIV) || (op_q == OP_MOD);
    is_logic  = (op_q == OP_AND) || (op_q == OP_OR);
    is_cmp    = !is_divmod && !is_logic && (op_q > OP_MUL);
    bad = (bm_q > BC_LEFT) || (lk_q > KIND_I64) || (rk_q > KIND_I64) || (op_q > OP_OR)
       || (is_divmod && (lk == KIND_BOOL || rk == KIND_BOOL))
       || (is_logic && (lk != KIND_BOOL || rk != KIND_BOOL));
    xa = sext_kind(a, lk);
    yb = sext_kind(b, rk);
    an = (xa == kind_min(lk));
    bn = (yb == kind_min(rk));
    lk8 = (lk == KIND_BOOL) ? KIND_I8 : lk;
    rk8 = (rk == KIND_BOOL) ? KIND_I8 : rk;

    item_o.bad  = bad;
    item_o.op   = bad ? OP_ADD : op_e'(op_q);
    item_o.resk = (lk8 > rk8) ? lk8 : rk8;
    if (is_cmp) item_o.pre_null = 1'b0;
    else        item_o.pre_null = an || bn || (is_divmod && (yb == '0));
    item_o.an   = an;
    item_o.bn   = bn;
    item_o.last = last_row_i;
    item_o.x    = xa;
    item_o.y    = yb;
    item_o.ax   = xa[63] ? (~xa + 64'd1) : xa;
    item_o.ay   = yb[63] ? (~yb + 64'd1) : yb;
    item_o.res  = '0;
  end

endmodule

/* sv/nacalu_fifo.sv */
`timescale 1ns / 1ps
module nacalu_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  nacalu_pkg::item_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output nacalu_pkg::item_t data_o
);
  import nacalu_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);

  item_t             mem_q [FifoDepth];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [PtrW:0]     cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop)  rptr_q <= rptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (!do_push && do_pop) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_data_i;
  end

endmodule

/* sv/nacalu_back.sv */
`timescale 1ns / 1ps
module nacalu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  nacalu_pkg::item_t item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [63:0]       result_value_o,
  output logic              result_null_o,
  output logic              unsupported_o,
  output logic              last_out_o
);
  import nacalu_pkg::*;

  item_t             pipe_q [PostStage+1];
  logic [PostStage:0] vld_q;
  logic [63:0]       rem_q [1:DivStages];
  logic [63:0]       dq_q  [1:DivStages];
  logic [63:0]       dvs_q [1:DivStages];
  logic [63:0]       pp_ll_q;
  logic [31:0]       pp_lh_q, pp_hl_q;
  logic              adv, out_valid_q;

  // whole pipe moves as one; stalls only when the output beat is held
  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[PostStage-1:0], valid_i};
      out_valid_q <= vld_q[PostStage];
    end
  end

  // stage 1: add, sub, compare, logic; multiplier partial products
  logic [63:0] simple;
  logic        both, any, gt, lt, eq;
  always_comb begin
    eq   = (pipe_q[0].x == pipe_q[0].y);
    gt   = ($signed(pipe_q[0].x) > $signed(pipe_q[0].y));
    lt   = ($signed(pipe_q[0].x) < $signed(pipe_q[0].y));
    both = pipe_q[0].an && pipe_q[0].bn;
    any  = pipe_q[0].an || pipe_q[0].bn;
    case (pipe_q[0].op)
      OP_ADD: simple = pipe_q[0].x + pipe_q[0].y;
      OP_SUB: simple = pipe_q[0].x - pipe_q[0].y;
      OP_EQ:  simple = {63'd0, both || (!any && eq)};
      OP_NE:  simple = {63'd0, !both && (any || !eq)};
      OP_GT:  simple = {63'd0, !any && gt};
      OP_LT:  simple = {63'd0, !any && lt};
      OP_GE:  simple = {63'd0, both || (!any && !lt)};
      OP_LE:  simple = {63'd0, both || (!any && !gt)};
      OP_AND: simple = {63'd0, (pipe_q[0].x != '0) && (pipe_q[0].y != '0)};
      OP_OR:  simple = {63'd0, (pipe_q[0].x != '0) || (pipe_q[0].y != '0)};
      default: simple = '0;
    endcase
  end

  logic [63:0] mul_sum;
  logic [31:0] mid;
  assign mid     = pp_lh_q + pp_hl_q;
  assign mul_sum = pp_ll_q + {mid, 32'd0};

  // post stage: floor quotient and divisor-signed remainder
  logic [63:0] qm, rm, dres;
  logic        xs, ys, rnz;
  always_comb begin
    qm  = dq_q[DivStages];
    rm  = rem_q[DivStages];
    xs  = pipe_q[DivStages].x[63];
    ys  = pipe_q[DivStages].y[63];
    rnz = (rm != '0);
    if (pipe_q[DivStages].op == OP_DIV) begin
      if (xs ^ ys) dres = rnz ? ~qm : (~qm + 64'd1);
      else         dres = qm;
    end else begin
      if ((xs ^ ys) && rnz) dres = xs ? (pipe_q[DivStages].y - rm) : (pipe_q[DivStages].y + rm);
      else                  dres = xs ? (~rm + 64'd1) : rm;
    end
  end

  // stage items with their result filled in where that stage produces it
  item_t st1, st2, stp;
  always_comb begin
    st1     = pipe_q[0];
    st1.res = simple;
    st2     = pipe_q[1];
    if (pipe_q[1].op == OP_MUL) st2.res = mul_sum;
    stp     = pipe_q[DivStages];
    if (pipe_q[DivStages].op == OP_DIV || pipe_q[DivStages].op == OP_MOD) stp.res = dres;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pipe_q[0] <= item_i;
      pipe_q[1] <= st1;
      pp_ll_q <= 64'(pipe_q[0].x[31:0] * pipe_q[0].y[31:0]);
      pp_lh_q <= 32'(pipe_q[0].x[31:0] * pipe_q[0].y[63:32]);
      pp_hl_q <= 32'(pipe_q[0].x[63:32] * pipe_q[0].y[31:0]);
      pipe_q[2] <= st2;
      for (int k = 3; k <= DivStages; k++) pipe_q[k] <= pipe_q[k-1];
      pipe_q[PostStage] <= stp;
    end
  end

  // restoring divider on magnitudes, one quotient bit per stage
  for (genvar k = 1; k <= DivStages; k++) begin : g_div
    logic [63:0] rem_in, dq_in, dvs_in;
    logic [64:0] sh;
    logic        ge;
    if (k == 1) begin : g_first
      assign rem_in = '0;
      assign dq_in  = pipe_q[0].ax;
      assign dvs_in = pipe_q[0].ay;
    end else begin : g_rest
      assign rem_in = rem_q[k-1];
      assign dq_in  = dq_q[k-1];
      assign dvs_in = dvs_q[k-1];
    end
    assign sh = {rem_in, dq_in[63]};
    assign ge = (sh >= {1'b0, dvs_in});
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[k] <= ge ? 64'(sh - {1'b0, dvs_in}) : sh[63:0];
        dq_q[k]  <= {dq_in[62:0], ge};
        dvs_q[k] <= dvs_in;
      end
    end
  end

  // output register
  logic [63:0] tr, fin_val;
  logic        fin_null;
  item_t       p;
  always_comb begin
    p  = pipe_q[PostStage];
    tr = sext_kind(p.res, p.resk);
    if (p.bad) begin
      fin_val  = '0;
      fin_null = 1'b0;
    end else if (p.pre_null) begin
      fin_val  = kind_min(p.resk);
      fin_null = 1'b1;
    end else begin
      fin_val  = tr;
      fin_null = (p.op <= OP_MOD) && (tr == kind_min(p.resk));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      result_value_o <= fin_val;
      result_null_o  <= fin_null;
      unsupported_o  <= p.bad;
      last_out_o     <= p.last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* sv/null_aware_column_alu.sv */
`timescale 1ns / 1ps
// Throughput: one row per cycle unless the output beat is held; the
//   64-stage bit-per-stage divider and the split 64-bit multiplier are
//   fully pipelined, so every operation streams.
// Reset (rst_ni low, async): registers go to add, int8/int8, no broadcast,
//   scalar 0; queue and pipeline valids clear; payload flops are not reset.
module null_aware_column_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  // row input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] operand_a_i,
  input  logic [63:0] operand_b_i,
  input  logic        last_row_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_value_o,
  output logic        result_null_o,
  output logic        unsupported_o,
  output logic        last_out_o
);
  import nacalu_pkg::*;

  item_t front_item, q_item;
  logic  q_full, q_valid, q_pop;

  // front: config regs, broadcast select, kind truncation, null and
  // legality checks, operand magnitudes for the divider
  nacalu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .last_row_i  (last_row_i),
    .item_o      (front_item)
  );

  // small queue decouples input acceptance from back-end stalls
  assign in_ready_o = !q_full;

  nacalu_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_item)
  );

  // back: lockstep pipeline, stalls only while the output beat waits
  nacalu_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .item_i         (q_item),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_value_o (result_value_o),
    .result_null_o  (result_null_o),
    .unsupported_o  (unsupported_o),
    .last_out_o     (last_out_o)
  );

endmodule
